// ===== rtl/gtg_pkg.sv =====
`timescale 1ns / 1ps

package gtg_pkg;

    // Field and register widths.
    localparam int POS_W        = 16;
    localparam int HEAD_W       = 16;
    localparam int CFG_W        = 16;
    localparam int TOL_W        = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_W        = 16;

    // Position difference: one bit more than a position.
    localparam int DIFF_W       = POS_W + 1;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 14;
    localparam int PRESCALE_W   = 16;
    localparam int XW           = 36;
    localparam int ZW           = 34;

    // Distance scaling by 1/K in Q0.24.
    localparam int INV_W        = 24;
    localparam logic [INV_W-1:0] INV_GAIN_Q24 = 24'd10188014;
    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

    localparam int HI_W         = XW - PRESCALE_W;
    localparam int PHI_W        = HI_W + INV_W;
    localparam int PLO_W        = PRESCALE_W + INV_W;
    localparam int DIST_W       = PHI_W + 1 - INV_W;

    // Bearing and heading error.
    localparam int BEAR_W       = ZW - 17;
    localparam int HERR_W       = BEAR_W + 1;
    localparam int TPROD_W      = CFG_W + 1 + HERR_W;
    localparam int TFULL_W      = TPROD_W + 1 - 13;

    // Speed division.
    localparam int LGD_W        = CFG_W + DIST_W;
    localparam int NUM_W        = LGD_W + 2;
    localparam int DEN_W        = CFG_W + 1;
    localparam int QUOT_W       = OUT_W - 1;
    localparam int REM_W        = DEN_W + QUOT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_X       = 3'd0,
        CFG_GOAL_Y       = 3'd1,
        CFG_ARRIVE_TOL   = 3'd2,
        CFG_TRAVEL_TIME  = 3'd3,
        CFG_LINEAR_GAIN  = 3'd4,
        CFG_ANGULAR_GAIN = 3'd5
    } cfg_idx_t;

    // Information that rides alongside the speed division.
    typedef struct packed {
        logic                    arrived;
        logic                    sat_spd;
        logic                    sat_turn;
        logic signed [OUT_W-1:0] turn;
    } gtg_side_t;

    // atan(2^-i) in units of 2^-30 rad.
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 34'sh03243F6A8;
            1:  r = 34'sh01DAC6705;
            2:  r = 34'sh00FADBAFC;
            3:  r = 34'sh007F56EA6;
            4:  r = 34'sh003FEAB76;
            5:  r = 34'sh001FFD55B;
            6:  r = 34'sh000FFFAAA;
            7:  r = 34'sh0007FFF55;
            8:  r = 34'sh0003FFFEA;
            9:  r = 34'sh0001FFFFD;
            10: r = 34'sh0000FFFFF;
            11: r = 34'sh00007FFFF;
            12: r = 34'sh00003FFFF;
            13: r = 34'sh00001FFFF;
            14: r = 34'sh00000FFFF;
            15: r = 34'sh000007FFF;
            16: r = 34'sh000003FFF;
            17: r = 34'sh000001FFF;
            18: r = 34'sh000000FFF;
            19: r = 34'sh0000007FF;
            20: r = 34'sh0000003FF;
            21: r = 34'sh0000001FF;
            22: r = 34'sh0000000FF;
            23: r = 34'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/go_to_goal_p_controller_unit.sv =====
`timescale 1ns / 1ps

// Proportional go-to-goal controller for a unicycle robot. Each input word is a
// pose (x, y in signed Q8.8, heading in signed Q3.13); each output word carries
// the forward speed and turn rate commands (signed Q8.8) with the arrived and
// saturated flags. The pipeline takes one word per clock when not stalled. Each
// word passes one pre-rotation stage and fourteen CORDIC vectoring stages,
// four stages of scaling, gain multiplies and clipping, fifteen stages of a
// restoring divider for the speed, and the output register. The whole pipeline
// moves forward whenever the output register is empty or its word is being
// taken, so s_tready follows m_tready with no further delay. The turn command
// uses the raw bearing minus heading, without wrapping to plus or minus pi.
// Configuration registers may be rewritten only while no word is in flight.

module go_to_goal_p_controller_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gtg_pkg::CFG_W-1:0]            cfg_wdata,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,   // pose_x, pose_y, pose_heading

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata,   // forward_speed, turn_rate
    output logic [1:0]                           m_tuser    // arrived, saturated
);

    // Configuration registers.
    logic signed [gtg_pkg::POS_W-1:0] goal_x_reg;
    logic signed [gtg_pkg::POS_W-1:0] goal_y_reg;
    logic [gtg_pkg::TOL_W-1:0]        tol_reg;
    logic [gtg_pkg::CFG_W-1:0]        travel_time_reg;
    logic [gtg_pkg::CFG_W-1:0]        lin_gain_reg;
    logic [gtg_pkg::CFG_W-1:0]        ang_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            tol_reg         <= 15'd128;
            travel_time_reg <= 16'd256;
            lin_gain_reg    <= 16'd1152;
            ang_gain_reg    <= 16'd1024;
        end else if (cfg_wr_en) begin
            case (gtg_pkg::cfg_idx_t'(cfg_index))
                gtg_pkg::CFG_GOAL_X:       goal_x_reg      <= cfg_wdata;
                gtg_pkg::CFG_GOAL_Y:       goal_y_reg      <= cfg_wdata;
                gtg_pkg::CFG_ARRIVE_TOL:   tol_reg         <= cfg_wdata[gtg_pkg::TOL_W-1:0];
                gtg_pkg::CFG_TRAVEL_TIME:  travel_time_reg <= cfg_wdata;
                gtg_pkg::CFG_LINEAR_GAIN:  lin_gain_reg    <= cfg_wdata;
                gtg_pkg::CFG_ANGULAR_GAIN: ang_gain_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves when the output register can take a word.
    logic m_tvalid_reg;
    logic en;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Vector from the pose to the goal.
    logic signed [gtg_pkg::POS_W-1:0]  pose_x;
    logic signed [gtg_pkg::POS_W-1:0]  pose_y;
    logic signed [gtg_pkg::HEAD_W-1:0] pose_heading;
    logic signed [gtg_pkg::DIFF_W-1:0] dx;
    logic signed [gtg_pkg::DIFF_W-1:0] dy;

    assign pose_x       = s_tdata[15:0];
    assign pose_y       = s_tdata[31:16];
    assign pose_heading = s_tdata[47:32];
    assign dx = gtg_pkg::DIFF_W'(goal_x_reg) - gtg_pkg::DIFF_W'(pose_x);
    assign dy = gtg_pkg::DIFF_W'(goal_y_reg) - gtg_pkg::DIFF_W'(pose_y);

    logic                              c_valid;
    logic signed [gtg_pkg::XW-1:0]     c_x;
    logic signed [gtg_pkg::ZW-1:0]     c_z;
    logic signed [gtg_pkg::HEAD_W-1:0] c_heading;

    gtg_cordic u_cordic (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .dx          (dx),
        .dy          (dy),
        .heading     (pose_heading),
        .out_valid   (c_valid),
        .x_out       (c_x),
        .z_out       (c_z),
        .heading_out (c_heading)
    );

    // Stage 1: scale the magnitude by 1/K in two partial products, and form the
    // heading error from the rounded bearing.
    logic                               s1_v_reg;
    logic [gtg_pkg::PHI_W-1:0]          s1_phi_reg;
    logic [gtg_pkg::PLO_W-1:0]          s1_plo_reg;
    logic signed [gtg_pkg::HERR_W-1:0]  s1_herr_reg;
    logic signed [gtg_pkg::ZW-1:0]      bear_sum;
    logic signed [gtg_pkg::BEAR_W-1:0]  bearing;

    assign bear_sum = c_z + gtg_pkg::ZW'(65536);
    assign bearing  = bear_sum[gtg_pkg::ZW-1:17];

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_phi_reg  <= c_x[gtg_pkg::XW-1:gtg_pkg::PRESCALE_W] * gtg_pkg::INV_GAIN_Q24;
            s1_plo_reg  <= c_x[gtg_pkg::PRESCALE_W-1:0] * gtg_pkg::INV_GAIN_Q24;
            s1_herr_reg <= gtg_pkg::HERR_W'(bearing) - gtg_pkg::HERR_W'(c_heading);
        end
    end

    // Stage 2: distance in Q8.8 and the turn product.
    logic                               s2_v_reg;
    logic [gtg_pkg::DIST_W-1:0]         s2_dist_reg;
    logic signed [gtg_pkg::TPROD_W-1:0] s2_tprod_reg;
    logic [gtg_pkg::PHI_W:0]            dist_sum;

    assign dist_sum = {1'b0, s1_phi_reg}
                    + (gtg_pkg::PHI_W+1)'(s1_plo_reg[gtg_pkg::PLO_W-1:gtg_pkg::PRESCALE_W]);

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_dist_reg  <= dist_sum[gtg_pkg::PHI_W:gtg_pkg::INV_W];
            s2_tprod_reg <= gtg_pkg::TPROD_W'($signed({1'b0, ang_gain_reg}))
                          * gtg_pkg::TPROD_W'(s1_herr_reg);
        end
    end

    // Stage 3: arrival test, speed product, turn rounding and clipping.
    logic                               s3_v_reg;
    logic                               s3_arrived_reg;
    logic [gtg_pkg::LGD_W-1:0]          s3_lgd_reg;
    logic signed [gtg_pkg::OUT_W-1:0]   s3_turn_reg;
    logic                               s3_sat_turn_reg;
    logic signed [gtg_pkg::TPROD_W:0]   turn_sum;
    logic signed [gtg_pkg::TFULL_W-1:0] turn_full;
    logic                               turn_hi;
    logic                               turn_lo;

    assign turn_sum  = (gtg_pkg::TPROD_W+1)'(s2_tprod_reg) + (gtg_pkg::TPROD_W+1)'(4096);
    assign turn_full = turn_sum[gtg_pkg::TPROD_W:13];
    assign turn_hi   = turn_full > gtg_pkg::TFULL_W'(32767);
    assign turn_lo   = turn_full < -gtg_pkg::TFULL_W'(32768);

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_arrived_reg  <= s2_dist_reg <= gtg_pkg::DIST_W'(tol_reg);
            s3_lgd_reg      <= lin_gain_reg * s2_dist_reg;
            s3_sat_turn_reg <= turn_hi || turn_lo;
            if (turn_hi) begin
                s3_turn_reg <= 16'sh7FFF;
            end else if (turn_lo) begin
                s3_turn_reg <= -16'sh8000;
            end else begin
                s3_turn_reg <= turn_full[gtg_pkg::OUT_W-1:0];
            end
        end
    end

    // Stage 4: round-half-up numerator and doubled denominator; a quotient that
    // cannot fit in 15 bits is caught here so the divider sees a bounded value.
    logic                        s4_v_reg;
    logic [gtg_pkg::REM_W-1:0]   s4_num_reg;
    logic [gtg_pkg::DEN_W-1:0]   s4_den_reg;
    gtg_pkg::gtg_side_t          s4_side_reg;
    logic [gtg_pkg::CFG_W-1:0]   tt_eff;
    logic [gtg_pkg::NUM_W-1:0]   num_full;
    logic [gtg_pkg::DEN_W-1:0]   den_full;
    logic                        sat_spd;

    assign tt_eff   = (travel_time_reg == '0) ? gtg_pkg::CFG_W'(1) : travel_time_reg;
    assign num_full = {s3_lgd_reg, 1'b0} + gtg_pkg::NUM_W'(tt_eff);
    assign den_full = {tt_eff, 1'b0};
    assign sat_spd  = num_full >= (gtg_pkg::NUM_W'(den_full) << gtg_pkg::QUOT_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_num_reg           <= sat_spd ? '0 : num_full[gtg_pkg::REM_W-1:0];
            s4_den_reg           <= den_full;
            s4_side_reg.arrived  <= s3_arrived_reg;
            s4_side_reg.sat_spd  <= sat_spd;
            s4_side_reg.sat_turn <= s3_sat_turn_reg;
            s4_side_reg.turn     <= s3_turn_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= c_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    logic                       d_valid;
    logic [gtg_pkg::QUOT_W-1:0] d_quot;
    gtg_pkg::gtg_side_t         d_side;

    gtg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s4_v_reg),
        .num       (s4_num_reg),
        .den       (s4_den_reg),
        .side_in   (s4_side_reg),
        .out_valid (d_valid),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    // Output register: arrival forces both commands and the saturated flag to zero.
    logic [gtg_pkg::OUT_W-1:0] spd_reg;
    logic [gtg_pkg::OUT_W-1:0] turn_reg;
    logic                      arrived_reg;
    logic                      sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            arrived_reg <= d_side.arrived;
            if (d_side.arrived) begin
                spd_reg  <= '0;
                turn_reg <= '0;
                sat_reg  <= 1'b0;
            end else begin
                spd_reg  <= d_side.sat_spd ? 16'h7FFF : {1'b0, d_quot};
                turn_reg <= d_side.turn;
                sat_reg  <= d_side.sat_spd || d_side.sat_turn;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {turn_reg, spd_reg};
    assign m_tuser  = {sat_reg, arrived_reg};

    // The forward speed command is never negative.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !spd_reg[gtg_pkg::OUT_W-1])
        else $error("forward speed word is negative");

    // An arrived word carries zero commands and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && arrived_reg) |-> (spd_reg == '0 && turn_reg == '0 && !sat_reg))
        else $error("arrived word carries nonzero commands");

    // A word is never accepted while the output register holds a stalled word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !(m_tvalid && !m_tready))
        else $error("input accepted during output stall");

    // A stalled pipeline freezes the divider output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(d_valid) && $stable(d_quot))
        else $error("divider output moved during stall");

endmodule

// ===== rtl/gtg_cordic.sv =====
`timescale 1ns / 1ps

module gtg_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [gtg_pkg::DIFF_W-1:0] dx,
    input  logic signed [gtg_pkg::DIFF_W-1:0] dy,
    input  logic signed [gtg_pkg::HEAD_W-1:0] heading,
    output logic                              out_valid,
    output logic signed [gtg_pkg::XW-1:0]     x_out,
    output logic signed [gtg_pkg::ZW-1:0]     z_out,
    output logic signed [gtg_pkg::HEAD_W-1:0] heading_out
);

    localparam int N = gtg_pkg::CORDIC_STEPS;

    logic                              v_reg [0:N];
    logic signed [gtg_pkg::XW-1:0]     x_reg [0:N];
    logic signed [gtg_pkg::XW-1:0]     y_reg [0:N];
    logic signed [gtg_pkg::ZW-1:0]     z_reg [0:N];
    logic signed [gtg_pkg::HEAD_W-1:0] h_reg [0:N];

    logic signed [gtg_pkg::XW-1:0] dx_s;
    logic signed [gtg_pkg::XW-1:0] dy_s;

    assign dx_s = {{(gtg_pkg::XW-gtg_pkg::DIFF_W-gtg_pkg::PRESCALE_W){dx[gtg_pkg::DIFF_W-1]}},
                   dx, {gtg_pkg::PRESCALE_W{1'b0}}};
    assign dy_s = {{(gtg_pkg::XW-gtg_pkg::DIFF_W-gtg_pkg::PRESCALE_W){dy[gtg_pkg::DIFF_W-1]}},
                   dy, {gtg_pkg::PRESCALE_W{1'b0}}};

    // Pre-rotation into the right half plane.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg[0] <= heading;
            if (dx[gtg_pkg::DIFF_W-1]) begin
                x_reg[0] <= -dx_s;
                y_reg[0] <= -dy_s;
                z_reg[0] <= dy[gtg_pkg::DIFF_W-1] ? -gtg_pkg::PI_Q30 : gtg_pkg::PI_Q30;
            end else begin
                x_reg[0] <= dx_s;
                y_reg[0] <= dy_s;
                z_reg[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                h_reg[i+1] <= h_reg[i];
                if (!y_reg[i][gtg_pkg::XW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + gtg_pkg::atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - gtg_pkg::atan_q30(i);
                end
            end
        end
    end

    assign out_valid   = v_reg[N];
    assign x_out       = x_reg[N];
    assign z_out       = z_reg[N];
    assign heading_out = h_reg[N];

endmodule

// ===== rtl/gtg_div.sv =====
`timescale 1ns / 1ps

module gtg_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [gtg_pkg::REM_W-1:0]         num,
    input  logic [gtg_pkg::DEN_W-1:0]         den,
    input  gtg_pkg::gtg_side_t                side_in,
    output logic                              out_valid,
    output logic [gtg_pkg::QUOT_W-1:0]        quot,
    output gtg_pkg::gtg_side_t                side_out
);

    localparam int Q = gtg_pkg::QUOT_W;

    logic                        v_reg    [1:Q];
    logic [gtg_pkg::REM_W-1:0]   rem_reg  [1:Q];
    logic [gtg_pkg::QUOT_W-1:0]  q_reg    [1:Q];
    logic [gtg_pkg::DEN_W-1:0]   den_reg  [1:Q];
    gtg_pkg::gtg_side_t          side_reg [1:Q];

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 1; j <= Q; j++) begin : g_bit
        localparam int SH = Q - j;

        logic                       v_cur;
        logic [gtg_pkg::REM_W-1:0]  rem_cur;
        logic [gtg_pkg::QUOT_W-1:0] q_cur;
        logic [gtg_pkg::DEN_W-1:0]  den_cur;
        gtg_pkg::gtg_side_t         side_cur;
        logic [gtg_pkg::REM_W:0]    trial;

        if (j == 1) begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = num;
            assign q_cur    = '0;
            assign den_cur  = den;
            assign side_cur = side_in;
        end else begin : g_next
            assign v_cur    = v_reg[j-1];
            assign rem_cur  = rem_reg[j-1];
            assign q_cur    = q_reg[j-1];
            assign den_cur  = den_reg[j-1];
            assign side_cur = side_reg[j-1];
        end

        assign trial = {1'b0, rem_cur} - ((gtg_pkg::REM_W+1)'(den_cur) << SH);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j]  <= den_cur;
                side_reg[j] <= side_cur;
                q_reg[j]    <= q_cur | ((gtg_pkg::QUOT_W)'(!trial[gtg_pkg::REM_W]) << SH);
                rem_reg[j]  <= trial[gtg_pkg::REM_W] ? rem_cur : trial[gtg_pkg::REM_W-1:0];
            end
        end
    end

    assign out_valid = v_reg[Q];
    assign quot      = q_reg[Q];
    assign side_out  = side_reg[Q];

endmodule
